// ----- rtl/core/psa_pkg.sv -----
`timescale 1ns / 1ps

package psa_pkg;

    localparam int unsigned DataW = 64;

    typedef enum logic [2:0] {
        MODE_NOT   = 3'd0,
        MODE_SHR   = 3'd1,
        MODE_SHL   = 3'd2,
        MODE_XOR   = 3'd3,
        MODE_OR    = 3'd4,
        MODE_AND   = 3'd5,
        MODE_ADD   = 3'd6,
        MODE_ADDUS = 3'd7
    } mode_t;

    // Code 3 is unused and behaves as 32-bit lanes.
    typedef enum logic [1:0] {
        LANE_8  = 2'd0,
        LANE_16 = 2'd1,
        LANE_32 = 2'd2
    } lane_t;

    typedef logic [DataW-1:0] word_t;

endpackage

// ----- rtl/core/psa_lane_alu.sv -----
`timescale 1ns / 1ps

module psa_lane_alu (
    input  psa_pkg::mode_t mode,
    input  psa_pkg::lane_t lane_size,
    input  psa_pkg::word_t operand_a,
    input  psa_pkg::word_t operand_b,
    output psa_pkg::word_t result
);
    import psa_pkg::*;

    word_t shr8, shl8, add8, sat8;
    word_t shr16, shl16, add16, sat16;
    word_t shr32, shl32, add32, sat32;
    logic  big8, big16, big32;

    // Shift count comes from lane 0 of operand A; any count past the lane zeroes it.
    assign big8  = (operand_a[7:3]  != '0);
    assign big16 = (operand_a[15:4] != '0);
    assign big32 = (operand_a[31:5] != '0);

    always_comb begin
        logic [8:0]  s8;
        logic [16:0] s16;
        logic [32:0] s32;
        shr8  = '0;
        shl8  = '0;
        add8  = '0;
        sat8  = '0;
        shr16 = '0;
        shl16 = '0;
        add16 = '0;
        sat16 = '0;
        shr32 = '0;
        shl32 = '0;
        add32 = '0;
        sat32 = '0;
        s8    = '0;
        s16   = '0;
        s32   = '0;
        for (int i = 0; i < DataW / 8; i++) begin
            shr8[i*8 +: 8] = big8 ? 8'd0 : (operand_b[i*8 +: 8] >> operand_a[2:0]);
            shl8[i*8 +: 8] = big8 ? 8'd0 : (operand_b[i*8 +: 8] << operand_a[2:0]);
            s8 = {1'b0, operand_a[i*8 +: 8]} + {1'b0, operand_b[i*8 +: 8]};
            add8[i*8 +: 8] = s8[7:0];
            sat8[i*8 +: 8] = s8[8] ? 8'hff : s8[7:0];
        end
        for (int i = 0; i < DataW / 16; i++) begin
            shr16[i*16 +: 16] = big16 ? 16'd0 : (operand_b[i*16 +: 16] >> operand_a[3:0]);
            shl16[i*16 +: 16] = big16 ? 16'd0 : (operand_b[i*16 +: 16] << operand_a[3:0]);
            s16 = {1'b0, operand_a[i*16 +: 16]} + {1'b0, operand_b[i*16 +: 16]};
            add16[i*16 +: 16] = s16[15:0];
            sat16[i*16 +: 16] = s16[16] ? 16'hffff : s16[15:0];
        end
        for (int i = 0; i < DataW / 32; i++) begin
            shr32[i*32 +: 32] = big32 ? 32'd0 : (operand_b[i*32 +: 32] >> operand_a[4:0]);
            shl32[i*32 +: 32] = big32 ? 32'd0 : (operand_b[i*32 +: 32] << operand_a[4:0]);
            s32 = {1'b0, operand_a[i*32 +: 32]} + {1'b0, operand_b[i*32 +: 32]};
            add32[i*32 +: 32] = s32[31:0];
            sat32[i*32 +: 32] = s32[32] ? 32'hffff_ffff : s32[31:0];
        end
    end

    always_comb begin
        word_t shr_w, shl_w, add_w, sat_w;
        case (lane_size)
            LANE_8: begin
                shr_w = shr8;
                shl_w = shl8;
                add_w = add8;
                sat_w = sat8;
            end
            LANE_16: begin
                shr_w = shr16;
                shl_w = shl16;
                add_w = add16;
                sat_w = sat16;
            end
            default: begin
                shr_w = shr32;
                shl_w = shl32;
                add_w = add32;
                sat_w = sat32;
            end
        endcase
        case (mode)
            MODE_NOT:   result = ~operand_a;
            MODE_SHR:   result = shr_w;
            MODE_SHL:   result = shl_w;
            MODE_XOR:   result = operand_a ^ operand_b;
            MODE_OR:    result = operand_a | operand_b;
            MODE_AND:   result = operand_a & operand_b;
            MODE_ADD:   result = add_w;
            default:    result = sat_w;
        endcase
    end

endmodule

// ----- rtl/core/packed_simd_alu_64_unit.sv -----
`timescale 1ns / 1ps

// Packed SIMD ALU on 64-bit words with 8, 16 or 32-bit lanes (lane 0 in the low bits).
// A beat is captured in an input register, goes through one pass of lane logic and
// lands in a result register; a new beat is taken every cycle while m_ready stays
// high. The two registers form a pipeline whose ready path runs back from m_ready;
// a stalled output holds at most two beats in flight. Lane size code 3 acts as
// 32-bit lanes.
module packed_simd_alu_64_unit (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  psa_pkg::mode_t s_mode,
    input  psa_pkg::lane_t s_lane_size,
    input  psa_pkg::word_t s_operand_a,
    input  psa_pkg::word_t s_operand_b,
    output logic           m_valid,
    input  logic           m_ready,
    output psa_pkg::word_t m_result
);
    import psa_pkg::*;

    logic  in_valid_reg, in_valid_next;
    mode_t mode_reg;
    lane_t lane_size_reg;
    word_t operand_a_reg, operand_b_reg;
    logic  out_valid_reg, out_valid_next;
    word_t result_reg;
    word_t alu_result;
    logic  out_free;

    assign out_free = !out_valid_reg || m_ready;
    assign s_ready  = !in_valid_reg || out_free;

    // Advance the input stage into the result stage whenever the latter frees up.
    assign out_valid_next = out_free ? in_valid_reg : out_valid_reg;
    assign in_valid_next  = s_ready ? s_valid : in_valid_reg;

    psa_lane_alu u_alu (
        .mode      (mode_reg),
        .lane_size (lane_size_reg),
        .operand_a (operand_a_reg),
        .operand_b (operand_b_reg),
        .result    (alu_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            mode_reg      <= s_mode;
            lane_size_reg <= s_lane_size;
            operand_a_reg <= s_operand_a;
            operand_b_reg <= s_operand_b;
        end
        if (out_free && in_valid_reg) begin
            result_reg <= alu_result;
        end
    end

    assign m_valid  = out_valid_reg;
    assign m_result = result_reg;

endmodule

// ----- rtl/core/psa_checker.sv -----
`timescale 1ns / 1ps

module psa_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [63:0] m_result
);

    // Hold a stalled output beat.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result))
        else $error("stalled output beat dropped or changed");

    // No output beat right after reset.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

    // Input may only stall when the result register is full and blocked.
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without output backpressure");

    // A drained output leaves the input side ready, or a new output beat, in the next cycle.
    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |=> s_ready || m_valid)
        else $error("input blocked after drain");

endmodule

bind packed_simd_alu_64_unit psa_checker u_psa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_ready  (s_ready),
    .m_valid  (m_valid),
    .m_ready  (m_ready),
    .m_result (m_result)
);
